FILE: design/vau_pkg.sv
package vau_pkg;

    typedef enum logic [2:0] {
        MODE_ADD   = 3'd0,
        MODE_SUB   = 3'd1,
        MODE_SCALE = 3'd2,
        MODE_DOT   = 3'd3,
        MODE_CROSS = 3'd4,
        MODE_LEN   = 3'd5,
        MODE_NORM  = 3'd6
    } t_mode;

    typedef struct packed {
        logic  valid;
        t_mode mode;
    } t_ctl;

endpackage

FILE: design/vau_front.sv
module vau_front #(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  vau_pkg::t_ctl          i_ctl,
    input  logic [2:0][W-1:0]      i_a,
    input  logic [2:0][W-1:0]      i_b,
    input  logic [W-1:0]           i_f,
    output vau_pkg::t_ctl          o_ctl,
    output logic [2:0][W-1:0]      o_r,
    output logic [2*W-1:0]         o_sc,
    output logic [2*W-1:0]         o_s,
    output logic [2:0][W-1:0]      o_a
);
    import vau_pkg::*;

    localparam int SW = 2 * W + 2;
    localparam logic signed [SW-1:0] HALF = (SW'(1) << F) >> 1;
    localparam logic signed [SW-1:0] VMAX = (SW'(1) << (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] VMIN = ~VMAX;
    localparam logic signed [SW-1:0] SMAX = (SW'(1) << (2 * W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v);
        return (v + HALF) >>> F;
    endfunction

    function automatic logic [W-1:0] sat_v(input logic signed [SW-1:0] v);
        logic [W-1:0] res;
        if (v > VMAX) res = VMAX[W-1:0];
        else if (v < VMIN) res = VMIN[W-1:0];
        else res = v[W-1:0];
        return res;
    endfunction

    function automatic logic [2*W-1:0] sat_s(input logic signed [SW-1:0] v);
        logic [2*W-1:0] res;
        if (v > SMAX) res = SMAX[2*W-1:0];
        else if (v < SMIN) res = SMIN[2*W-1:0];
        else res = v[2*W-1:0];
        return res;
    endfunction

    t_ctl              r_c0, r_c1, r_c2;
    logic [2:0][W-1:0] r_a0, r_b0, r_a1, r_b1, r_a2;
    logic [W-1:0]      r_f0;
    logic signed [W-1:0]   x [6];
    logic signed [W-1:0]   y [6];
    logic signed [2*W-1:0] n_p [6];
    logic signed [2*W-1:0] r_p [6];
    logic signed [SW-1:0]  e [6];
    logic signed [SW-1:0]  ea [3];
    logic signed [SW-1:0]  eb [3];
    logic signed [SW-1:0]  sum3;
    logic [2:0][W-1:0] n_r, r_r2;
    logic [2*W-1:0]    n_sc, r_sc2, n_s, r_s2;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            x[k] = '0;
            y[k] = '0;
        end
        case (r_c0.mode)
            MODE_SCALE: begin
                for (int k = 0; k < 3; k++) begin
                    x[k] = $signed(r_a0[k]);
                    y[k] = $signed(r_f0);
                end
            end
            MODE_DOT: begin
                for (int k = 0; k < 3; k++) begin
                    x[k] = $signed(r_a0[k]);
                    y[k] = $signed(r_b0[k]);
                end
            end
            MODE_CROSS: begin
                x[0] = $signed(r_a0[1]); y[0] = $signed(r_b0[2]);
                x[1] = $signed(r_a0[2]); y[1] = $signed(r_b0[1]);
                x[2] = $signed(r_a0[2]); y[2] = $signed(r_b0[0]);
                x[3] = $signed(r_a0[0]); y[3] = $signed(r_b0[2]);
                x[4] = $signed(r_a0[0]); y[4] = $signed(r_b0[1]);
                x[5] = $signed(r_a0[1]); y[5] = $signed(r_b0[0]);
            end
            MODE_LEN, MODE_NORM: begin
                for (int k = 0; k < 3; k++) begin
                    x[k] = $signed(r_a0[k]);
                    y[k] = $signed(r_a0[k]);
                end
            end
            default: ;
        endcase
        for (int k = 0; k < 6; k++) n_p[k] = x[k] * y[k];
    end

    always_comb begin
        for (int k = 0; k < 6; k++) e[k] = SW'(r_p[k]);
        for (int k = 0; k < 3; k++) begin
            ea[k] = SW'($signed(r_a1[k]));
            eb[k] = SW'($signed(r_b1[k]));
        end
        sum3 = e[0] + e[1] + e[2];
        n_s  = sum3[2*W-1:0];
        n_r  = '0;
        n_sc = '0;
        case (r_c1.mode)
            MODE_ADD: for (int k = 0; k < 3; k++) n_r[k] = sat_v(ea[k] + eb[k]);
            MODE_SUB: for (int k = 0; k < 3; k++) n_r[k] = sat_v(ea[k] - eb[k]);
            MODE_SCALE: for (int k = 0; k < 3; k++) n_r[k] = sat_v(rnd(e[k]));
            MODE_DOT: n_sc = sat_s(sum3);
            MODE_CROSS: begin
                n_r[0] = sat_v(rnd(e[0] - e[1]));
                n_r[1] = sat_v(rnd(e[2] - e[3]));
                n_r[2] = sat_v(rnd(e[4] - e[5]));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
            r_c1 <= '0;
            r_c2 <= '0;
        end else if (i_en) begin
            r_c0 <= i_ctl;
            r_c1 <= r_c0;
            r_c2 <= r_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0  <= i_a;
            r_b0  <= i_b;
            r_f0  <= i_f;
            r_p   <= n_p;
            r_a1  <= r_a0;
            r_b1  <= r_b0;
            r_r2  <= n_r;
            r_sc2 <= n_sc;
            r_s2  <= n_s;
            r_a2  <= r_a1;
        end
    end

    assign o_ctl = r_c2;
    assign o_r   = r_r2;
    assign o_sc  = r_sc2;
    assign o_s   = r_s2;
    assign o_a   = r_a2;

endmodule

FILE: design/vau_sqrt.sv
module vau_sqrt #(
    parameter int W  = 16,
    parameter int F  = 8,
    parameter int PW = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  vau_pkg::t_ctl      i_ctl,
    input  logic [2*W-1:0]     i_s,
    input  logic [PW-1:0]      i_pass,
    output vau_pkg::t_ctl      o_ctl,
    output logic [W+F-1:0]     o_root,
    output logic [PW-1:0]      o_pass
);
    import vau_pkg::*;

    localparam int N = 2 * W + 2 * F;
    localparam int R = W + F;

    t_ctl         r_ctl  [R];
    logic [N-1:0] r_sv   [R];
    logic [R+1:0] r_rem  [R];
    logic [R-1:0] r_root [R];
    logic [PW-1:0] r_pass [R];

    for (genvar g = 0; g < R; g++) begin : g_stage
        t_ctl          c_in;
        logic [N-1:0]  s_in;
        logic [R+1:0]  rem_in;
        logic [R-1:0]  root_in;
        logic [PW-1:0] p_in;
        logic [R+1:0]  t, trial, n_rem;
        logic [R-1:0]  n_root;

        if (g == 0) begin : g_first
            assign c_in    = i_ctl;
            assign s_in    = N'(i_s) << (2 * F);
            assign rem_in  = '0;
            assign root_in = '0;
            assign p_in    = i_pass;
        end else begin : g_next
            assign c_in    = r_ctl[g-1];
            assign s_in    = r_sv[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign p_in    = r_pass[g-1];
        end

        always_comb begin
            t     = {rem_in[R-1:0], s_in[N-1-2*g -: 2]};
            trial = {root_in, 2'b01};
            if (t >= trial) begin
                n_rem  = t - trial;
                n_root = {root_in[R-2:0], 1'b1};
            end else begin
                n_rem  = t;
                n_root = {root_in[R-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g] <= '0;
            end else if (i_en) begin
                r_ctl[g] <= c_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sv[g]   <= s_in;
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_pass[g] <= p_in;
            end
        end
    end

    assign o_ctl  = r_ctl[R-1];
    assign o_root = r_root[R-1];
    assign o_pass = r_pass[R-1];

endmodule

FILE: design/vau_div.sv
module vau_div #(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  vau_pkg::t_ctl      i_ctl,
    input  logic [W+F-1:0]     i_root,
    input  logic [2:0][W-1:0]  i_a,
    input  logic [5*W-1:0]     i_pass,
    output vau_pkg::t_ctl      o_ctl,
    output logic [2:0][W-1:0]  o_r,
    output logic [2*W-1:0]     o_sc,
    output logic               o_zl
);
    import vau_pkg::*;

    localparam int R  = W + F;
    localparam int Q  = F + 1;
    localparam int DW = W + 2 * F;
    localparam int X  = W + F + 2;
    localparam int L  = R + 2 * W;
    localparam logic signed [X-1:0] VMAX = (X'(1) << (W - 1)) - X'(1);
    localparam logic signed [X-1:0] VMIN = ~VMAX;
    localparam logic [L-1:0] SMAX = (L'(1) << (2 * W - 1)) - L'(1);

    t_ctl               r_ctl  [Q];
    logic [2:0][DW-1:0] r_rem  [Q];
    logic [2:0][Q-1:0]  r_q    [Q];
    logic [2:0]         r_neg  [Q];
    logic [R-1:0]       r_root [Q];
    logic [5*W-1:0]     r_pass [Q];

    for (genvar g = 0; g < Q; g++) begin : g_stage
        localparam int K = F - g;
        t_ctl               c_in;
        logic [2:0][DW-1:0] rem_in, n_rem;
        logic [2:0][Q-1:0]  q_in, n_q;
        logic [2:0]         neg_in;
        logic [R-1:0]       root_in;
        logic [5*W-1:0]     p_in;
        logic [DW-1:0]      dv;

        if (g == 0) begin : g_first
            for (genvar i = 0; i < 3; i++) begin : g_comp
                assign neg_in[i] = i_a[i][W-1];
                assign rem_in[i] = DW'(i_a[i][W-1] ? W'(-i_a[i]) : i_a[i]) << (2 * F);
            end
            assign c_in    = i_ctl;
            assign q_in    = '0;
            assign root_in = i_root;
            assign p_in    = i_pass;
        end else begin : g_next
            assign c_in    = r_ctl[g-1];
            assign rem_in  = r_rem[g-1];
            assign q_in    = r_q[g-1];
            assign neg_in  = r_neg[g-1];
            assign root_in = r_root[g-1];
            assign p_in    = r_pass[g-1];
        end

        always_comb begin
            dv    = DW'(root_in) << K;
            n_rem = rem_in;
            n_q   = q_in;
            for (int i = 0; i < 3; i++) begin
                if (rem_in[i] >= dv) begin
                    n_rem[i]  = rem_in[i] - dv;
                    n_q[i][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g] <= '0;
            end else if (i_en) begin
                r_ctl[g] <= c_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_q[g]    <= n_q;
                r_neg[g]  <= neg_in;
                r_root[g] <= root_in;
                r_pass[g] <= p_in;
            end
        end
    end

    logic signed [X-1:0] qv [3];
    logic [R-1:0]        root;
    t_ctl                c_out;

    assign root  = r_root[Q-1];
    assign c_out = r_ctl[Q-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qv[i] = r_neg[Q-1][i] ? -X'(r_q[Q-1][i]) : X'(r_q[Q-1][i]);
        end
        o_r  = r_pass[Q-1][3*W-1:0];
        o_sc = r_pass[Q-1][5*W-1:3*W];
        o_zl = 1'b0;
        case (c_out.mode)
            MODE_LEN: begin
                o_sc = (L'(root) > SMAX) ? SMAX[2*W-1:0] : (2*W)'(root);
            end
            MODE_NORM: begin
                o_sc = '0;
                if (root == '0) begin
                    o_r  = '0;
                    o_zl = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (qv[i] > VMAX) o_r[i] = VMAX[W-1:0];
                        else if (qv[i] < VMIN) o_r[i] = VMIN[W-1:0];
                        else o_r[i] = qv[i][W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_ctl = c_out;

endmodule

FILE: design/vec3_arith_unit.sv
// Channel   Dir  Signals                          Contents
// slave     in   i_s_tvalid/o_s_tready/i_s_tdata  ax ay az bx by bz factor; tuser: mode
// master    out  o_m_tvalid/i_m_tready/o_m_tdata  rx ry rz scalar_out; tuser: zero_length
//
// The pipeline has three front stages (input, multiply, combine), one square root stage per
// root bit, one divide stage per quotient bit, and the output register. One word is taken
// every cycle while the skid register is empty.
// Reset clears all valid bits; payload registers are not reset.
// A skid register behind the output register takes one more word while a result waits;
// the pipeline holds only while that skid register is full.
module vec3_arith_unit #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // ax, ay, az, bx, by, bz, factor
    input  logic [((7*COMP_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // mode
    input  logic [2:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // rx, ry, rz, scalar_out
    output logic [((5*COMP_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // zero_length
    output logic [0:0]                        o_m_tuser
);
    import vau_pkg::*;

    localparam int W   = COMP_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int TDO = ((5 * W + 7) / 8) * 8;
    localparam int PW  = 8 * W;

    logic              en;
    t_ctl              in_ctl, f_ctl, s_ctl, d_ctl;
    logic [2:0][W-1:0] in_a, in_b, f_r, f_a, d_r, s_a;
    logic [2*W-1:0]    f_sc, f_s, d_sc;
    logic [W+F-1:0]    s_root;
    logic [PW-1:0]     s_pass;
    logic              d_zl;
    logic [TDO-1:0]    n_word, r_out_data, r_sk_data;
    logic              r_out_zl, r_sk_zl;
    logic              r_out_v, r_skid_v;

    assign en         = !r_skid_v;
    assign o_s_tready = en;

    assign in_ctl.valid = i_s_tvalid;
    assign in_ctl.mode  = t_mode'(i_s_tuser);
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign in_a[i] = i_s_tdata[i*W +: W];
        assign in_b[i] = i_s_tdata[(i+3)*W +: W];
    end

    vau_front #(.W(W), .F(F)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (in_ctl),
        .i_a     (in_a),
        .i_b     (in_b),
        .i_f     (i_s_tdata[6*W +: W]),
        .o_ctl   (f_ctl),
        .o_r     (f_r),
        .o_sc    (f_sc),
        .o_s     (f_s),
        .o_a     (f_a)
    );

    vau_sqrt #(.W(W), .F(F), .PW(PW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (f_ctl),
        .i_s     (f_s),
        .i_pass  ({f_a, f_sc, f_r}),
        .o_ctl   (s_ctl),
        .o_root  (s_root),
        .o_pass  (s_pass)
    );

    assign s_a = s_pass[PW-1:5*W];

    vau_div #(.W(W), .F(F)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (s_ctl),
        .i_root  (s_root),
        .i_a     (s_a),
        .i_pass  (s_pass[5*W-1:0]),
        .o_ctl   (d_ctl),
        .o_r     (d_r),
        .o_sc    (d_sc),
        .o_zl    (d_zl)
    );

    assign n_word = TDO'({d_sc, d_r});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            r_out_v  <= r_skid_v || d_ctl.valid;
            r_skid_v <= 1'b0;
        end else if (en && d_ctl.valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_tready) begin
            if (r_skid_v) begin
                r_out_data <= r_sk_data;
                r_out_zl   <= r_sk_zl;
            end else begin
                r_out_data <= n_word;
                r_out_zl   <= d_zl;
            end
        end else if (en) begin
            r_sk_data <= n_word;
            r_sk_zl   <= d_zl;
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_zl;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full with output register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_tready))
        else $error("skid register filled while output moved");

    a_zero_len_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("zero length result carries nonzero data");
`endif

endmodule
